FILE: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, register codes and types of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int PIX_W      = CHAN_W * NUM_CHAN;
    localparam int SUM_W      = 12;
    localparam int POS_W      = 12;
    localparam int CFG_DIM_W  = 13;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_DIM_W-1:0] RST_FRAME_WIDTH  = CFG_DIM_W'(640);
    localparam logic [CFG_DIM_W-1:0] RST_FRAME_HEIGHT = CFG_DIM_W'(480);
    localparam logic                 RST_USE_MAX_MODE = 1'b1;

    localparam logic [7:0] EDGE_SAT = 8'd255;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_USE_MAX_MODE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [POS_W-1:0] centre_col;
        logic [POS_W-1:0] centre_row;
        logic             produce;
        logic             last;
    } pos_t;

endpackage

FILE: rtl/sem_raster_ctr.sv
// ----------------------------------------------------------------------------
// sem_raster_ctr
// Column and row counters of the raster stream, with dimension clamping.
// ----------------------------------------------------------------------------
module sem_raster_ctr
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic [CFG_DIM_W-1:0] frame_width,
    input  logic [CFG_DIM_W-1:0] frame_height,
    output logic [CW-1:0]        addr,
    output pos_t                 pos
);

    localparam int DW = (CW + 1 > CFG_DIM_W) ? CW + 1 : CFG_DIM_W;
    localparam int DH = (RW + 1 > CFG_DIM_W) ? RW + 1 : CFG_DIM_W;

    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [DW-1:0] w, fw, col_ext, col_cur;
    logic [DH-1:0] h, fh, row_ext, row_wrap, row_cur, row_inc;

    always_comb begin
        fw = DW'(frame_width);
        fh = DH'(frame_height);
        if (fw < DW'(3)) begin
            w = DW'(3);
        end else if (fw > DW'(MAX_WIDTH)) begin
            w = DW'(MAX_WIDTH);
        end else begin
            w = fw;
        end
        if (fh < DH'(3)) begin
            h = DH'(3);
        end else if (fh > DH'(MAX_HEIGHT)) begin
            h = DH'(MAX_HEIGHT);
        end else begin
            h = fh;
        end

        col_ext  = DW'(col_count_reg);
        row_ext  = DH'(row_count_reg);
        row_wrap = (row_ext >= h) ? '0 : row_ext;
        if (col_ext >= w) begin
            col_cur = '0;
            row_cur = (row_wrap + DH'(1) >= h) ? '0 : row_wrap + DH'(1);
        end else begin
            col_cur = col_ext;
            row_cur = row_wrap;
        end
        row_inc = (row_cur + DH'(1) >= h) ? '0 : row_cur + DH'(1);

        if (col_cur + DW'(1) >= w) begin
            col_count_next = '0;
            row_count_next = RW'(row_inc);
        end else begin
            col_count_next = CW'(col_cur + DW'(1));
            row_count_next = RW'(row_cur);
        end

        addr           = CW'(col_cur);
        pos.centre_col = POS_W'(32'(col_cur) - 32'd1);
        pos.centre_row = POS_W'(32'(row_cur) - 32'd1);
        pos.produce    = (col_cur >= DW'(2)) && (row_cur >= DH'(2));
        pos.last       = (col_cur == w - DW'(1)) && (row_cur == h - DH'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (advance) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

endmodule

FILE: rtl/sem_line_mem.sv
// ----------------------------------------------------------------------------
// sem_line_mem
// The two line stores: the row above and the row two above, one entry per
// column, synchronous read with registered data.
// ----------------------------------------------------------------------------
module sem_line_mem
    import sem_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_a,
    output logic [PIX_W-1:0] rd_b,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_a,
    input  logic [PIX_W-1:0] wr_b
);

    logic [PIX_W-1:0] store_a [DEPTH];
    logic [PIX_W-1:0] store_b [DEPTH];
    logic [PIX_W-1:0] rd_a_reg, rd_b_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= store_a[rd_addr];
            rd_b_reg <= store_b[rd_addr];
        end
        if (wr_en) begin
            store_a[wr_addr] <= wr_a;
            store_b[wr_addr] <= wr_b;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

    // Consecutive pixels sit in different columns, so the write-back of one
    // pixel never meets the read of the next at the same entry.
    a_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("line store read and write hit the same entry");

    a_read_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !rd_en |=> ($stable(rd_a) && $stable(rd_b)))
        else $error("line store read data changed during a stall");

endmodule

FILE: rtl/sem_gradient.sv
// ----------------------------------------------------------------------------
// sem_gradient
// 3x3 window of packed pixels and the horizontal and vertical Sobel sums
// over the three channels.
// ----------------------------------------------------------------------------
module sem_gradient
    import sem_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] top,
    input  logic [PIX_W-1:0] mid,
    input  logic [PIX_W-1:0] px,
    input  pos_t             pos_in,
    output logic             res_valid,
    output pos_t             res_pos,
    output logic [SUM_W-1:0] sh,
    output logic [SUM_W-1:0] sv
);

    localparam int TAP_W = CHAN_W + 2;

    logic [PIX_W-1:0] win_reg [9];
    logic             v2_reg, v3_reg;
    pos_t             pos2_reg, pos3_reg;
    logic [SUM_W-1:0] sh_reg, sv_reg, sh_sum, sv_sum;

    function automatic logic [CHAN_W-1:0] chan(input logic [PIX_W-1:0] p, input int k);
        return p[k*CHAN_W +: CHAN_W];
    endfunction

    function automatic logic [TAP_W-1:0] tap3(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [CHAN_W-1:0] c);
        return TAP_W'(a) + {1'b0, b, 1'b0} + TAP_W'(c);
    endfunction

    function automatic logic [TAP_W-1:0] abs_diff(input logic [TAP_W-1:0] a,
                                                  input logic [TAP_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always_comb begin
        sh_sum = '0;
        sv_sum = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            sh_sum = sh_sum + SUM_W'(abs_diff(
                tap3(chan(win_reg[0], k), chan(win_reg[3], k), chan(win_reg[6], k)),
                tap3(chan(win_reg[2], k), chan(win_reg[5], k), chan(win_reg[8], k))));
            sv_sum = sv_sum + SUM_W'(abs_diff(
                tap3(chan(win_reg[0], k), chan(win_reg[1], k), chan(win_reg[2], k)),
                tap3(chan(win_reg[6], k), chan(win_reg[7], k), chan(win_reg[8], k))));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            if (in_valid) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]     <= win_reg[r*3 + 1];
                    win_reg[r*3 + 1] <= win_reg[r*3 + 2];
                end
                win_reg[2] <= top;
                win_reg[5] <= mid;
                win_reg[8] <= px;
            end
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos2_reg <= pos_in;
            pos3_reg <= pos2_reg;
            sh_reg   <= sh_sum;
            sv_reg   <= sv_sum;
        end
    end

    assign res_valid = v3_reg;
    assign res_pos   = pos3_reg;
    assign sh        = sh_reg;
    assign sv        = sv_reg;

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_pos.produce) |-> ((sh <= SUM_W'(3060)) && (sv <= SUM_W'(3060))))
        else $error("Sobel sum out of range");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v3_reg) && $stable(sh_reg) && $stable(sv_reg)))
        else $error("gradient stage moved during a stall");

endmodule

FILE: rtl/sobel_edge_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude
// Colour Sobel edge magnitude over a raster pixel stream.
//
// Pixels enter on the s_ channel in raster order, one per transaction, three
// 8-bit channels in s_tdata. Each pixel whose column and row are both at
// least two completes a 3x3 window and gives one result transaction on the
// m_ channel for the window centre; border pixels give none. m_tlast marks
// the last interior result of a frame.
// One pixel is accepted per cycle unless a result waits on a stalled receiver.
// Each accepted pixel passes through line store read, window shift, Sobel
// sums, then mode select and saturation into the output register. The line
// stores are read and written back once per pixel, one port each, which sets
// the rate of one pixel per cycle.
// When a result waits on a stalled receiver, the output register holds it and
// the whole pipeline freezes; s_tready drops only while a result waits.
// Reset clears the counters, the window and the pipeline valid bits and sets the
// registers to 640 by 480 in max mode; the line stores keep no reset. The user
// writes registers over the APB port only while the stream is idle; unchecked.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,   // chan0, chan1, chan2
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // edge_value, centre_col, centre_row
    output logic                  m_tlast,   // frame_last
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic                 use_max_mode_reg;
    reg_index_t           reg_idx;
    logic                 cfg_wr;

    logic                 en, accept;
    logic [CW-1:0]        addr;
    pos_t                 pos;
    logic                 v1_reg;
    logic [CW-1:0]        addr1_reg;
    logic [PIX_W-1:0]     px1_reg;
    pos_t                 pos1_reg;
    logic [PIX_W-1:0]     rd_a, rd_b;

    logic                 res_valid;
    pos_t                 res_pos;
    logic [SUM_W-1:0]     sh, sv, sel_val;
    logic [SUM_W:0]       sum_hv;
    logic [SUM_W-1:0]     half_val;
    logic [7:0]           edge_val;

    logic                 m_tvalid_reg, m_tlast_reg;
    logic [31:0]          m_tdata_reg;

    assign pready  = 1'b1;
    assign reg_idx = reg_index_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            use_max_mode_reg <= RST_USE_MAX_MODE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_USE_MAX_MODE: use_max_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            REG_USE_MAX_MODE: prdata = APB_DATA_W'(use_max_mode_reg);
            default:          prdata = '0;
        endcase
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    sem_raster_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_ctr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .addr         (addr),
        .pos          (pos)
    );

    sem_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (en),
        .rd_addr (addr),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .wr_en   (en && v1_reg),
        .wr_addr (addr1_reg),
        .wr_a    (px1_reg),
        .wr_b    (rd_a)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr1_reg <= addr;
            px1_reg   <= s_tdata;
            pos1_reg  <= pos;
        end
    end

    sem_gradient u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v1_reg),
        .top       (rd_b),
        .mid       (rd_a),
        .px        (px1_reg),
        .pos_in    (pos1_reg),
        .res_valid (res_valid),
        .res_pos   (res_pos),
        .sh        (sh),
        .sv        (sv)
    );

    always_comb begin
        sum_hv = (SUM_W + 1)'(sh) + (SUM_W + 1)'(sv);
        if (use_max_mode_reg) begin
            sel_val = (sh > sv) ? sh : sv;
        end else begin
            sel_val = sum_hv[SUM_W:1];
        end
        half_val = sel_val >> 1;
        edge_val = (half_val > SUM_W'(EDGE_SAT)) ? EDGE_SAT : half_val[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= res_valid && res_pos.produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {res_pos.centre_row, res_pos.centre_col, edge_val};
            m_tlast_reg <= res_pos.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> ($stable(v1_reg) && $stable(addr1_reg) && $stable(px1_reg)))
        else $error("front stage moved during a stall");

    a_stall_only_on_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |-> (m_tvalid && !m_tready))
        else $error("input stalled without a waiting result");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams raster frames of colour pixels through the block and checks every
// edge result against a cycle-free predictor of the window arithmetic or a
// directed value. Frame sizes, clamped sizes and both magnitude modes are set
// over APB between frames and read back. Both stream sides idle and stall at
// random, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module testbench
    import sem_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_PAD = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_PIXELS = 600;
    localparam int LINE_DEPTH = DEF_MAX_WIDTH;

    typedef struct packed {
        logic [7:0]       edge_value;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } edge_result_t;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        reg_index_t   idx;
        logic [31:0]  value;
        logic [23:0]  px;
        bit           typed;
        edge_result_t want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sobel_edge_magnitude u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Predictor state.
    logic [CFG_DIM_W-1:0] cfg_width = RST_FRAME_WIDTH;
    logic [CFG_DIM_W-1:0] cfg_height = RST_FRAME_HEIGHT;
    logic                 cfg_max_mode = RST_USE_MAX_MODE;
    logic [PIX_W-1:0]     row_above [LINE_DEPTH];
    logic [PIX_W-1:0]     row_two_above [LINE_DEPTH];
    logic [PIX_W-1:0]     window [9];
    int                   col_pos = 0;
    int                   row_pos = 0;

    edge_result_t edge_queue [$];
    stim_row_t    directed [$];

    int error_count = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int frames_run = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic int abs_diff(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void sobel_step(input logic [PIX_W-1:0] px, output bit produced,
                                       output edge_result_t res);
        int w, h, col, row, sh, sv, mag, r, k;
        int tl, tm, tr, ml, mr, bl, bm, br;
        logic [PIX_W-1:0] top, mid;
        w = clamp_dim(cfg_width, DEF_MAX_WIDTH);
        h = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
        if (row_pos >= h) row_pos = 0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        col = col_pos;
        row = row_pos;
        top = row_two_above[col];
        mid = row_above[col];
        row_two_above[col] = mid;
        row_above[col] = px;
        for (r = 0; r < 3; r++) begin
            window[r*3] = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = px;
        produced = (col >= 2) && (row >= 2);
        res = '0;
        if (produced) begin
            sh = 0;
            sv = 0;
            for (k = 0; k < NUM_CHAN; k++) begin
                tl = window[0][8*k +: 8];
                tm = window[1][8*k +: 8];
                tr = window[2][8*k +: 8];
                ml = window[3][8*k +: 8];
                mr = window[5][8*k +: 8];
                bl = window[6][8*k +: 8];
                bm = window[7][8*k +: 8];
                br = window[8][8*k +: 8];
                sh += abs_diff(tl + 2*ml + bl, tr + 2*mr + br);
                sv += abs_diff(tl + 2*tm + tr, bl + 2*bm + br);
            end
            mag = cfg_max_mode ? ((sh > sv) ? sh : sv) : ((sh + sv) >> 1);
            mag = mag >> 1;
            if (mag > 255) mag = 255;
            res.edge_value = 8'(mag);
            res.col = POS_W'(col - 1);
            res.row = POS_W'(row - 1);
            res.last = (col == w - 1) && (row == h - 1);
        end
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_result(input logic [31:0] data, input logic last);
        edge_result_t want;
        if (edge_queue.size() == 0) begin
            report_mismatch($sformatf("result %h last %b with nothing expected", data, last));
            return;
        end
        want = edge_queue.pop_front();
        results_seen++;
        if (data[7:0] !== want.edge_value)
            report_mismatch($sformatf("edge_value %0d, expected %0d at (%0d,%0d)",
                                      data[7:0], want.edge_value, want.col, want.row));
        if (data[19:8] !== want.col)
            report_mismatch($sformatf("centre_col %0d, expected %0d", data[19:8], want.col));
        if (data[31:20] !== want.row)
            report_mismatch($sformatf("centre_row %0d, expected %0d", data[31:20], want.row));
        if (last !== want.last)
            report_mismatch($sformatf("frame_last %b, expected %b at (%0d,%0d)",
                                      last, want.last, want.col, want.row));
    endtask

    // Result side: checking, random stalls and the long hold-off.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result(m_tdata, m_tlast);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic apb_transfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_reg(input reg_index_t idx, input logic [31:0] want);
        logic [31:0] got;
        apb_transfer(1'b0, {idx, 2'b00}, '0, got);
        if (got !== want)
            report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                      idx.name(), got, want));
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] unused;
        logic [31:0] kept;
        apb_transfer(1'b1, {idx, 2'b00}, value, unused);
        case (idx)
            REG_FRAME_WIDTH: begin
                cfg_width = value[CFG_DIM_W-1:0];
                kept = 32'(cfg_width);
            end
            REG_FRAME_HEIGHT: begin
                cfg_height = value[CFG_DIM_W-1:0];
                kept = 32'(cfg_height);
            end
            default: begin
                cfg_max_mode = value[0];
                kept = 32'(cfg_max_mode);
            end
        endcase
        check_reg(idx, kept);
    endtask

    // Lets every pending result drain before the registers change.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (edge_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input edge_result_t want);
        bit produced;
        edge_result_t res;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        sobel_step(px, produced, res);
        if (produced) edge_queue.push_back(typed ? want : res);
    endtask

    task automatic set_phase(input int phase);
        case (phase)
            1: begin tx_idle_pct = 51; rx_stall_pct = 0; end
            2: begin tx_idle_pct = 0; rx_stall_pct = 51; end
            3: begin tx_idle_pct = 36; rx_stall_pct = 36; end
            default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        endcase
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(input int style, input int c, input int r);
        logic [PIX_W-1:0] px;
        int k;
        px = '0;
        for (k = 0; k < NUM_CHAN; k++) begin
            case (style)
                0: px[8*k +: 8] = 8'($urandom());
                1: px[8*k +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: px[8*k +: 8] = 8'(c*37 + r*23 + k*50 + $urandom_range(0, 15));
            endcase
        end
        return px;
    endfunction

    task automatic run_frame(input logic [CFG_DIM_W-1:0] wval, input logic [CFG_DIM_W-1:0] hval,
                             input logic mode, input int style, input int phase);
        int w, h, r, c;
        quiesce();
        write_reg(REG_FRAME_WIDTH, {19'($urandom()), wval});
        write_reg(REG_FRAME_HEIGHT, {19'($urandom()), hval});
        write_reg(REG_USE_MAX_MODE, {31'($urandom()), mode});
        set_phase(phase);
        w = clamp_dim(wval, DEF_MAX_WIDTH);
        h = clamp_dim(hval, DEF_MAX_HEIGHT);
        for (r = 0; r < h; r++)
            for (c = 0; c < w; c++)
                send_pixel(make_pixel(style, c, r), 1'b0, '0);
        frames_run++;
    endtask

    task automatic add_pixel(input logic [PIX_W-1:0] px, input bit typed,
                             input edge_result_t want);
        stim_row_t row;
        row.kind = ROW_PIXEL;
        row.idx = REG_FRAME_WIDTH;
        row.value = '0;
        row.px = px;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endtask

    task automatic add_write(input reg_index_t idx, input logic [31:0] value);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.idx = idx;
        row.value = value;
        row.px = '0;
        row.typed = 1'b0;
        row.want = '0;
        directed.push_back(row);
    endtask

    initial begin
        int i, frame, style;
        bit pressed;
        for (i = 0; i < LINE_DEPTH; i++) begin
            row_above[i] = '0;
            row_two_above[i] = '0;
        end
        for (i = 0; i < 9; i++) window[i] = '0;

        // A 3x3 frame with a vertical step in the first channel, max mode.
        add_write(REG_FRAME_WIDTH, 32'd3);
        add_write(REG_FRAME_HEIGHT, 32'd3);
        add_write(REG_USE_MAX_MODE, 32'd1);
        for (i = 0; i < 8; i++) add_pixel((i % 3 == 0) ? 24'h000064 : 24'h0, 1'b0, '0);
        add_pixel(24'h0, 1'b1, '{edge_value: 8'd200, col: 12'd1, row: 12'd1, last: 1'b1});
        // Sizes below the minimum clamp to 3; a white top row saturates in mean mode.
        add_write(REG_FRAME_WIDTH, 32'd0);
        add_write(REG_FRAME_HEIGHT, 32'd2);
        add_write(REG_USE_MAX_MODE, 32'd0);
        for (i = 0; i < 8; i++) add_pixel((i < 3) ? 24'hFFFFFF : 24'h0, 1'b0, '0);
        add_pixel(24'h0, 1'b1, '{edge_value: EDGE_SAT, col: 12'd1, row: 12'd1, last: 1'b1});
        // The same step in mean mode stays below saturation.
        add_write(REG_FRAME_WIDTH, 32'd3);
        for (i = 0; i < 8; i++) add_pixel((i % 3 == 0) ? 24'h000064 : 24'h0, 1'b0, '0);
        add_pixel(24'h0, 1'b1, '{edge_value: 8'd100, col: 12'd1, row: 12'd1, last: 1'b1});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        check_reg(REG_FRAME_WIDTH, 32'(RST_FRAME_WIDTH));
        check_reg(REG_FRAME_HEIGHT, 32'(RST_FRAME_HEIGHT));
        check_reg(REG_USE_MAX_MODE, 32'(RST_USE_MAX_MODE));

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_WRITE) begin
                quiesce();
                write_reg(directed[i].idx, directed[i].value);
            end else begin
                send_pixel(directed[i].px, directed[i].typed, directed[i].want);
            end
        end
        frames_run += 3;

        frame = 0;
        pressed = 1'b0;
        while (pixels_sent < 27 + RANDOM_PIXELS) begin
            style = $urandom_range(0, 2);
            if (!pressed && frame == 3) begin
                // The receiver holds off while a larger frame keeps coming.
                pressed = 1'b1;
                quiesce();
                hold_requests++;
                run_frame(13'd12, 13'd8, 1'($urandom()), style, 0);
            end else begin
                run_frame(13'($urandom_range(0, 12)), 13'($urandom_range(0, 8)),
                          1'($urandom()), style, ((pixels_sent - 27) / 150) % 4);
            end
            frame++;
        end

        // Largest sizes, written with every size bit set, over the start of a frame.
        quiesce();
        write_reg(REG_FRAME_WIDTH, 32'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 32'd3);
        write_reg(REG_USE_MAX_MODE, 32'd1);
        for (i = 0; i < 24; i++) send_pixel(make_pixel(0, i, 0), 1'b0, '0);
        quiesce();
        write_reg(REG_FRAME_WIDTH, 32'd3);
        write_reg(REG_FRAME_HEIGHT, 32'h1FFF);
        write_reg(REG_USE_MAX_MODE, 32'd0);
        for (i = 0; i < 30; i++) send_pixel(make_pixel(1, i % 3, i / 3), 1'b0, '0);
        run_frame(13'd4, 13'd4, 1'b1, 0, 3);

        s_tvalid <= 1'b0;
        while (edge_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);

        $display("Sent %0d pixels in %0d frames and checked %0d edge results,",
                 pixels_sent, frames_run, results_seen);
        $display("covering both modes, clamped and largest sizes, idling and a long hold-off.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", error_count);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
